// File: hw/rtl/telnet_option_responder_defines.svh
// Assertion helpers for the RTL modules (used by tor_burst).
`ifndef TELNET_OPTION_RESPONDER_DEFINES_SVH
`define TELNET_OPTION_RESPONDER_DEFINES_SVH

// Checked only while out of reset.
`define TOR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tor assertion failed");

// Checked at every edge, reset included.
`define TOR_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("tor assertion failed");

`endif

// File: hw/rtl/tor_pkg.sv
package tor_pkg;

  // Telnet command codes
  localparam logic [7:0] IAC_CODE = 8'd255;
  localparam logic [7:0] CMD_WILL = 8'd251;
  localparam logic [7:0] CMD_WONT = 8'd252;
  localparam logic [7:0] CMD_DO   = 8'd253;
  localparam logic [7:0] CMD_DONT = 8'd254;
  localparam logic [7:0] CMD_SB   = 8'd250;
  localparam logic [7:0] CMD_SE   = 8'd240;

  // Option numbers that get a reply
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;
  localparam logic [7:0] OPT_TTYPE  = 8'd24;
  localparam logic [7:0] OPT_NAWS   = 8'd31;
  localparam logic [7:0] OPT_TSPEED = 8'd32;
  localparam logic [7:0] OPT_XDISP  = 8'd35;
  localparam logic [7:0] OPT_ENV    = 8'd39;

  // Size values
  localparam logic [7:0] SIZE_MAX = 8'd254;
  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [7:0] ROWS_RESET = 8'd24;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROWS    = 1'd1;

  // Beat index within one burst (longest burst is 18 beats)
  localparam int unsigned IDX_W = 5;

  // Positions of the size bytes in the window size reply
  localparam logic [IDX_W-1:0] NAWS_COLS_POS = 5'd7;
  localparam logic [IDX_W-1:0] NAWS_ROWS_POS = 5'd9;

  typedef enum logic [1:0] {
    ESC_IDLE  = 2'd0,
    ESC_CMD   = 2'd1,
    ESC_OPT   = 2'd2,
    ESC_SPARE = 2'd3
  } esc_pos_e;

  typedef enum logic [2:0] {
    KIND_DISPLAY,
    KIND_ECHO,
    KIND_SGA,
    KIND_TTYPE,
    KIND_NAWS,
    KIND_TSPEED,
    KIND_XDISP,
    KIND_ENV
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } job_t;

  localparam logic [7:0] ECHO_REPLY [6] = '{
    8'hFF, 8'hFC, 8'h01, 8'hFF, 8'hFD, 8'h01
  };

  localparam logic [7:0] TTYPE_REPLY [16] = '{
    8'hFF, 8'hFB, 8'h18,
    8'hFF, 8'hFA, 8'h18, 8'h00, 8'h56, 8'h54, 8'h35, 8'h32, 8'hFF, 8'hF0,
    8'hFF, 8'hFE, 8'h11
  };

  localparam logic [7:0] NAWS_REPLY [12] = '{
    8'hFF, 8'hFB, 8'h1F,
    8'hFF, 8'hFA, 8'h1F, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hF0
  };

  localparam logic [7:0] TSPEED_REPLY [18] = '{
    8'hFF, 8'hFB, 8'h20,
    8'hFF, 8'hFA, 8'h20, 8'h00,
    8'h32, 8'h34, 8'h30, 8'h30, 8'h2C, 8'h32, 8'h34, 8'h30, 8'h30,
    8'hFF, 8'hF0
  };

  // A size of 255 would look like IAC; send it as 254
  function automatic logic [7:0] clip_size(input logic [7:0] v);
    return (v == IAC_CODE) ? SIZE_MAX : v;
  endfunction

  // Number of beats produced by one job
  function automatic logic [IDX_W-1:0] reply_len(input kind_e kind);
    logic [IDX_W-1:0] len;
    case (kind)
      KIND_DISPLAY: len = 5'd1;
      KIND_ECHO:    len = 5'd6;
      KIND_SGA:     len = 5'd3;
      KIND_TTYPE:   len = 5'd16;
      KIND_NAWS:    len = 5'd12;
      KIND_TSPEED:  len = 5'd18;
      KIND_XDISP:   len = 5'd3;
      KIND_ENV:     len = 5'd3;
      default:      len = 5'd1;
    endcase
    return len;
  endfunction

  // Three-beat negotiation: IAC, command, option
  function automatic logic [7:0] short_reply(input logic [1:0] idx,
                                              input logic [7:0] cmd,
                                              input logic [7:0] opt);
    logic [7:0] b;
    case (idx)
      2'd0:    b = IAC_CODE;
      2'd1:    b = cmd;
      default: b = opt;
    endcase
    return b;
  endfunction

  // Byte for beat idx of a job
  function automatic logic [7:0] reply_byte(input kind_e kind,
                                             input logic [IDX_W-1:0] idx,
                                             input logic [7:0] data,
                                             input logic [7:0] cols,
                                             input logic [7:0] rows);
    logic [7:0] b;
    case (kind)
      KIND_DISPLAY: b = data;
      KIND_ECHO:    b = ECHO_REPLY[idx[2:0]];
      KIND_SGA:     b = short_reply(idx[1:0], CMD_DO, OPT_SGA);
      KIND_TTYPE:   b = TTYPE_REPLY[idx[3:0]];
      KIND_NAWS: begin
        if (idx == NAWS_COLS_POS) begin
          b = clip_size(cols);
        end else if (idx == NAWS_ROWS_POS) begin
          b = clip_size(rows);
        end else begin
          b = NAWS_REPLY[idx[3:0]];
        end
      end
      KIND_TSPEED:  b = TSPEED_REPLY[idx];
      KIND_XDISP:   b = short_reply(idx[1:0], CMD_WONT, OPT_XDISP);
      KIND_ENV:     b = short_reply(idx[1:0], CMD_WONT, OPT_ENV);
      default:      b = data;
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/tor_intf.sv
// Received byte channel
interface tor_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result beat channel
interface tor_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       to_host;
  logic       last;

  modport source (output valid, output out_byte, output to_host, output last, input ready);
  modport sink   (input valid, input out_byte, input to_host, input last, output ready);
endinterface

// Configuration write channel
interface tor_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/telnet_option_responder.sv
// Display bytes: job register, then result register, to tx; one byte per cycle while tx is ready.
// Escape bytes (IAC, command, unknown option) produce no beat and load no job.
// Replies: 3 to 18 beats, one per cycle from the reply sequencer while tx is ready; rx stalls
// until the last beat has left the job register.
// Reset: escape state idle, pipeline empty, window size 80 columns by 24 rows.
module telnet_option_responder
  import tor_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  tor_rx_if.sink    rx_i,
  tor_tx_if.source  tx_o,
  tor_cfg_if.sink   cfg_i
);

  logic       job_valid;
  logic       job_ready;
  job_t       job;
  logic [7:0] cols_q;
  logic [7:0] rows_q;
  logic       cfg_write;

  // Window size registers
  assign cfg_i.ready = 1'b1;
  assign cfg_write   = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLUMNS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_i.index)
        REG_WINDOW_COLUMNS: cols_q <= cfg_i.data;
        REG_WINDOW_ROWS:    rows_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  tor_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  tor_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .cols_i      (cols_q),
    .rows_i      (rows_q),
    .tx_o        (tx_o)
  );

endmodule

// File: hw/rtl/tor_parser.sv
module tor_parser
  import tor_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  tor_rx_if.sink rx_i,
  output logic  job_valid_o,
  input  logic  job_ready_i,
  output job_t  job_o
);

  esc_pos_e esc_q, esc_d;
  logic     job_valid_q, job_valid_d;
  job_t     job_q, job_d;
  logic     accept;
  logic     load;
  kind_e    opt_kind;
  logic     opt_known;

  // Take a byte whenever the job register is free or draining this cycle
  assign rx_i.ready = !job_valid_q || job_ready_i;
  assign accept     = rx_i.valid && rx_i.ready;

  // Option decode
  always_comb begin
    opt_kind  = KIND_DISPLAY;
    opt_known = 1'b1;
    unique case (rx_i.rx_byte)
      OPT_ECHO:   opt_kind = KIND_ECHO;
      OPT_SGA:    opt_kind = KIND_SGA;
      OPT_TTYPE:  opt_kind = KIND_TTYPE;
      OPT_NAWS:   opt_kind = KIND_NAWS;
      OPT_TSPEED: opt_kind = KIND_TSPEED;
      OPT_XDISP:  opt_kind = KIND_XDISP;
      OPT_ENV:    opt_kind = KIND_ENV;
      default:    opt_known = 1'b0;
    endcase
  end

  // Escape state: next state
  always_comb begin
    esc_d = esc_q;
    if (accept) begin
      unique case (esc_q)
        ESC_IDLE: if (rx_i.rx_byte == IAC_CODE) esc_d = ESC_CMD;
        ESC_CMD:  esc_d = ESC_OPT;
        ESC_OPT,
        ESC_SPARE: esc_d = ESC_IDLE;
        default:  esc_d = ESC_IDLE;
      endcase
    end
  end

  // Escape state: job produced by this byte
  always_comb begin
    load       = 1'b0;
    job_d      = job_q;
    unique case (esc_q)
      ESC_IDLE: begin
        load       = accept && (rx_i.rx_byte != IAC_CODE);
        job_d.kind = KIND_DISPLAY;
      end
      ESC_CMD: begin
        load = 1'b0;
      end
      ESC_OPT, ESC_SPARE: begin
        load       = accept && opt_known;
        job_d.kind = opt_kind;
      end
      default: load = 1'b0;
    endcase
    job_d.data = rx_i.rx_byte;
  end

  always_comb begin
    if (load) begin
      job_valid_d = 1'b1;
    end else if (job_ready_i) begin
      job_valid_d = 1'b0;
    end else begin
      job_valid_d = job_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q       <= ESC_IDLE;
      job_valid_q <= 1'b0;
    end else begin
      esc_q       <= esc_d;
      job_valid_q <= job_valid_d;
    end
  end

  // Job payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

endmodule

// File: hw/rtl/tor_burst.sv
`include "telnet_option_responder_defines.svh"

module tor_burst
  import tor_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  input  job_t       job_i,
  input  logic [7:0] cols_i,
  input  logic [7:0] rows_i,
  tor_tx_if.source   tx_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] len;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q;
  logic             to_host_q;
  logic             last_q;
  logic             out_free;
  logic             emit;
  logic             last_beat;

  // One beat per cycle while the output register can take it
  assign len         = reply_len(job_i.kind);
  assign out_free    = !out_valid_q || tx_o.ready;
  assign emit        = job_valid_i && out_free;
  assign last_beat   = (idx_q == len - 5'd1);
  assign job_ready_o = emit && last_beat;

  always_comb begin
    idx_d = idx_q;
    if (emit) begin
      idx_d = last_beat ? '0 : idx_q + 5'd1;
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (tx_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= reply_byte(job_i.kind, idx_q, job_i.data, cols_i, rows_i);
      to_host_q  <= (job_i.kind != KIND_DISPLAY);
      last_q     <= last_beat;
    end
  end

  assign tx_o.valid    = out_valid_q;
  assign tx_o.out_byte = out_byte_q;
  assign tx_o.to_host  = to_host_q;
  assign tx_o.last     = last_q;

  // Beat counter never runs past the burst
  `TOR_ASSERT(a_idx_in_range, job_valid_i |-> (idx_q < len))
  // A burst in progress keeps its job
  `TOR_ASSERT(a_idx_needs_job, (idx_q != '0) |-> job_valid_i)
  // A display byte is a single beat for the display
  `TOR_ASSERT(a_display_single,
              (emit && (job_i.kind == KIND_DISPLAY)) |=> (last_q && !to_host_q))

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import tor_pkg::*;

  // No-accept cycles before the run is declared hung
  localparam int unsigned STALL_LIMIT = 2000;
  // Cycles the sink holds ready low during the pressure test
  localparam int unsigned HOLD_CYCLES = 150;
  // Cycles to let the pipeline go quiet after the last owed beat
  localparam int unsigned SETTLE_CYCLES = 8;

  localparam logic [7:0] KNOWN_OPTS [7] = '{
    OPT_ECHO, OPT_SGA, OPT_TTYPE, OPT_NAWS, OPT_TSPEED, OPT_XDISP, OPT_ENV
  };

  typedef struct packed {
    logic [7:0] data;
    logic       host;
    logic       last;
  } tx_beat_t;

  logic clk;
  logic rst_n;

  tor_rx_if  rx_if ();
  tor_tx_if  tx_if ();
  tor_cfg_if cfg_if ();

  telnet_option_responder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .tx_o   (tx_if),
    .cfg_i  (cfg_if)
  );

  // Shadow state of the responder
  esc_pos_e   esc_state;
  logic [7:0] win_cols;
  logic [7:0] win_rows;

  // Beats still owed by the block, oldest first
  tx_beat_t reply_q [$];

  int unsigned err_count;
  bit          rx_steady;
  bit          sink_steady;
  bit          hold_go;
  bit          sink_hold;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Expected-beat generation
  // ---------------------------------------------------------------------------

  function automatic void push_host(input logic [7:0] b);
    reply_q.push_back('{data: b, host: 1'b1, last: 1'b0});
  endfunction

  function automatic void push_neg(input logic [7:0] cmd, input logic [7:0] opt);
    push_host(IAC_CODE);
    push_host(cmd);
    push_host(opt);
  endfunction

  // IAC SB opt 0 <text> IAC SE
  function automatic void push_sub(input logic [7:0] opt, input string text);
    push_host(IAC_CODE);
    push_host(CMD_SB);
    push_host(opt);
    push_host(8'd0);
    for (int i = 0; i < text.len(); i++) begin
      push_host(text[i]);
    end
    push_host(IAC_CODE);
    push_host(CMD_SE);
  endfunction

  // A size of 255 must not be mistaken for IAC
  function automatic logic [7:0] naws_size(input logic [7:0] v);
    return (v == 8'd255) ? 8'd254 : v;
  endfunction

  // Advance the shadow escape state by one received byte, queue its beats
  function automatic void predict_rx(input logic [7:0] c);
    int unsigned n0;
    n0 = reply_q.size();
    case (esc_state)
      ESC_IDLE: begin
        if (c == IAC_CODE) begin
          esc_state = ESC_CMD;
        end else begin
          reply_q.push_back('{data: c, host: 1'b0, last: 1'b0});
        end
      end
      ESC_CMD: begin
        esc_state = ESC_OPT;
      end
      default: begin
        esc_state = ESC_IDLE;
        case (c)
          OPT_ECHO: begin
            push_neg(CMD_WONT, OPT_ECHO);
            push_neg(CMD_DO, OPT_ECHO);
          end
          OPT_SGA: begin
            push_neg(CMD_DO, OPT_SGA);
          end
          OPT_TTYPE: begin
            push_neg(CMD_WILL, OPT_TTYPE);
            push_sub(OPT_TTYPE, "VT52");
            push_neg(CMD_DONT, 8'd17);
          end
          OPT_NAWS: begin
            push_neg(CMD_WILL, OPT_NAWS);
            push_host(IAC_CODE);
            push_host(CMD_SB);
            push_host(OPT_NAWS);
            push_host(8'd0);
            push_host(naws_size(win_cols));
            push_host(8'd0);
            push_host(naws_size(win_rows));
            push_host(IAC_CODE);
            push_host(CMD_SE);
          end
          OPT_TSPEED: begin
            push_neg(CMD_WILL, OPT_TSPEED);
            push_sub(OPT_TSPEED, "2400,2400");
          end
          OPT_XDISP: begin
            push_neg(CMD_WONT, OPT_XDISP);
          end
          OPT_ENV: begin
            push_neg(CMD_WONT, OPT_ENV);
          end
          default: begin
          end
        endcase
      end
    endcase
    if (reply_q.size() > n0) begin
      reply_q[reply_q.size() - 1].last = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one byte after a random gap; valid stays high if the next one follows at once
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = rx_steady ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    predict_rx(b);
  endtask

  task automatic send_escape(input logic [7:0] cmd, input logic [7:0] opt);
    send_byte(IAC_CODE);
    send_byte(cmd);
    send_byte(opt);
  endtask

  // Stop offering, wait for every owed beat, then let the pipeline go quiet
  task automatic drain_results();
    rx_if.valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both size registers back to back; block must be idle
  task automatic set_window(input logic [7:0] cols, input logic [7:0] rows);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_WINDOW_COLUMNS;
    cfg_if.data  <= cols;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    win_cols = cols;
    cfg_if.index <= REG_WINDOW_ROWS;
    cfg_if.data  <= rows;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    win_rows = rows;
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result sink and checker
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    tx_beat_t    want;
    int unsigned wait_left;
    wait_left = 0;
    tx_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && tx_if.valid && tx_if.ready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected beat out_byte %02h to_host %0b last %0b",
                   $time, tx_if.out_byte, tx_if.to_host, tx_if.last);
          err_count++;
        end else begin
          want = reply_q.pop_front();
          if (tx_if.out_byte !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, want.data, tx_if.out_byte);
            err_count++;
          end
          if (tx_if.to_host !== want.host) begin
            $display("%0t: to_host expected %0b actual %0b",
                     $time, want.host, tx_if.to_host);
            err_count++;
          end
          if (tx_if.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b",
                     $time, want.last, tx_if.last);
            err_count++;
          end
        end
        wait_left = sink_steady ? 0 : $urandom_range(0, 12);
      end else if (wait_left > 0) begin
        wait_left--;
      end
      tx_if.ready <= rst_n && !sink_hold && (wait_left == 0);
    end
  end

  // Long receiver hold-off, timed here so the sender keeps pushing meanwhile
  always begin
    wait (hold_go);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
    hold_go = 1'b0;
  end

  // Hang detection: any accepted beat on any channel resets the count
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Plain bytes pass straight to the display
  task automatic test_display_bytes();
    send_byte(8'h00);
    send_byte(8'hFE);
    send_byte(8'h41);
    send_byte(8'h80);
    drain_results();
  endtask

  // One escape per known option, window size at reset values, plus unknown options
  task automatic test_option_replies();
    send_escape(CMD_DO, OPT_ECHO);
    send_escape(CMD_WILL, OPT_SGA);
    send_escape(CMD_DO, OPT_TTYPE);
    send_escape(CMD_DO, OPT_NAWS);
    send_escape(CMD_DONT, OPT_TSPEED);
    send_escape(CMD_WONT, OPT_XDISP);
    send_escape(CMD_SB, OPT_ENV);
    // IAC IAC opens an escape; option 255 is unknown
    send_escape(IAC_CODE, 8'hFF);
    send_escape(8'h00, 8'h00);
    drain_results();
  endtask

  // Size extremes, including the values that must be clipped or passed as zero
  task automatic test_window_config();
    for (int i = 0; i < 4; i++) begin
      case (i)
        0:       set_window(8'd1, 8'd254);
        1:       set_window(8'd254, 8'd1);
        2:       set_window(8'd255, 8'd0);
        default: set_window(8'd0, 8'd255);
      endcase
      send_escape(CMD_DO, OPT_NAWS);
      send_byte(8'h2A);
      drain_results();
    end
  endtask

  // Sink stalls for a long stretch while bytes and a long reply keep coming
  task automatic test_output_stall();
    rx_steady = 1'b1;
    hold_go = 1'b1;
    for (int k = 0; k < 12; k++) begin
      send_byte(8'($urandom_range(0, 254)));
    end
    send_escape(CMD_DO, OPT_TSPEED);
    for (int k = 0; k < 8; k++) begin
      send_byte(8'($urandom_range(0, 254)));
    end
    send_escape(CMD_DO, OPT_TTYPE);
    rx_steady = 1'b0;
    drain_results();
  endtask

  // Mostly well-formed escapes with random content, plus noise and cut-off escapes
  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned run;
    logic [7:0]  cmd;
    logic [7:0]  opt;
    logic [7:0]  sizes [2];
    for (int round = 0; round < 55; round++) begin
      if (round % 16 == 0) begin
        rx_steady   = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
      end
      // New window size now and then, with the escape closed and the block quiet
      if (round % 30 == 29) begin
        while (esc_state != ESC_IDLE) send_byte(8'($urandom_range(0, 255)));
        drain_results();
        for (int j = 0; j < 2; j++) begin
          case ($urandom_range(0, 4))
            0:       sizes[j] = 8'd0;
            1:       sizes[j] = 8'd1;
            2:       sizes[j] = 8'd254;
            3:       sizes[j] = 8'd255;
            default: sizes[j] = 8'($urandom_range(0, 255));
          endcase
        end
        set_window(sizes[0], sizes[1]);
      end
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        case ($urandom_range(0, 5))
          0:       cmd = CMD_WILL;
          1:       cmd = CMD_WONT;
          2:       cmd = CMD_DO;
          3:       cmd = CMD_DONT;
          4:       cmd = CMD_SB;
          default: cmd = 8'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 4) != 0) begin
          opt = KNOWN_OPTS[3'($urandom_range(0, 6))];
        end else begin
          opt = 8'($urandom_range(0, 255));
        end
        send_escape(cmd, opt);
      end else if (pick <= 8) begin
        run = $urandom_range(1, 4);
        repeat (run) send_byte(8'($urandom_range(0, 255)));
      end else begin
        // Escape left open; following bytes finish it
        send_byte(IAC_CODE);
        run = $urandom_range(0, 2);
        repeat (run) send_byte(8'($urandom_range(0, 255)));
      end
    end
    rx_steady   = 1'b0;
    sink_steady = 1'b0;
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n = 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= REG_WINDOW_COLUMNS;
    cfg_if.data   <= 8'h00;
    esc_state = ESC_IDLE;
    win_cols  = COLUMNS_RESET;
    win_rows  = ROWS_RESET;
    err_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_display_bytes();
    test_option_replies();
    test_window_config();
    test_output_stall();
    test_random_traffic();

    repeat (20) @(posedge clk);
    if (err_count == 0 && reply_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
